>>> rtl/byte_memory_bus_rotated_loads_assert.svh
// assertion macros shared by the rtl modules
`ifndef BYTE_MEMORY_BUS_ROTATED_LOADS_ASSERT_SVH
`define BYTE_MEMORY_BUS_ROTATED_LOADS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BMB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define BMB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/bmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bmb_pkg;

   localparam int unsigned MEM_BYTES_DEFAULT = 65536;
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned QUEUE_DEPTH       = 2;
   localparam int unsigned QPTR_W            = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W            = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_DATA_W  = 17;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MSB_FIRST   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALID_BYTES = 1'd1;

   localparam logic [CSR_DATA_W-1:0] VALID_BYTES_RESET = 17'h10000;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef struct packed {
      logic        action;
      logic [1:0]  access_size;
      logic [31:0] address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        fault;
   } rsp_type;

   // classified access handed from front to back
   typedef struct packed {
      logic        write;
      logic        fault;
      logic        msb_first;
      logic [1:0]  last;      // byte count minus one
      logic [1:0]  rot;       // read rotation in bytes
      logic [31:0] address;   // first byte touched
      logic [31:0] write_data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // lane of the word that goes with byte offset k of the access
   function automatic logic [1:0] byte_lane(input logic big, input logic [1:0] last,
                                            input logic [1:0] k);
      byte_lane = big ? (last - k) : k;
   endfunction

   function automatic logic [7:0] get_byte(input logic [31:0] w, input logic [1:0] lane);
      get_byte = w[{lane, 3'b000} +: 8];
   endfunction

   function automatic logic [31:0] set_byte(input logic [31:0] w, input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = w;
      r[{lane, 3'b000} +: 8] = b;
      set_byte = r;
   endfunction

   function automatic logic [31:0] rotate_bytes(input logic [31:0] w, input logic [1:0] rot);
      case (rot)
         2'd1:    rotate_bytes = {w[7:0], w[31:8]};
         2'd2:    rotate_bytes = {w[15:0], w[31:16]};
         2'd3:    rotate_bytes = {w[23:0], w[31:24]};
         default: rotate_bytes = w;
      endcase
   endfunction

endpackage
`default_nettype wire

>>> rtl/bmb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bmb_ram #(
   parameter int unsigned WIDTH = bmb_pkg::BYTE_W,
   parameter int unsigned DEPTH = bmb_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> rtl/bmb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "byte_memory_bus_rotated_loads_assert.svh"
module bmb_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire bmb_pkg::cmd_type      push_cmd,
   input  wire logic                  pop,
   output bmb_pkg::cmd_type           head_cmd,
   output bmb_pkg::q_status_type      status
);
   import bmb_pkg::*;

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   `BMB_ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !status.full || pop)
   `BMB_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, !status.empty)
endmodule
`default_nettype wire

>>> rtl/bmb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bmb_front #(
   parameter int unsigned MEM_BYTES = bmb_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire bmb_pkg::req_type                    req_payload,
   output logic                                     busy,
   input  wire logic                                csr_write_en,
   input  wire logic [bmb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bmb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire bmb_pkg::q_status_type               q_status,
   output logic                                     push,
   output bmb_pkg::cmd_type                         push_cmd
);
   import bmb_pkg::*;

   logic                  msb_first_ff, msb_first_in;
   logic [CSR_DATA_W-1:0] valid_bytes_ff, valid_bytes_in;
   logic [1:0]            last;
   logic                  bad_size;
   logic [31:0]           base;
   logic [32:0]           limit;
   logic [32:0]           end_addr;

   always_comb begin
      msb_first_in   = msb_first_ff;
      valid_bytes_in = valid_bytes_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MSB_FIRST:   msb_first_in   = csr_wdata[0];
            CSR_VALID_BYTES: valid_bytes_in = csr_wdata;
            default:         msb_first_in   = msb_first_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msb_first_ff   <= 1'b0;
         valid_bytes_ff <= VALID_BYTES_RESET;
      end else begin
         msb_first_ff   <= msb_first_in;
         valid_bytes_ff <= valid_bytes_in;
      end
   end

   always_comb begin
      bad_size = 1'b0;
      unique case (req_payload.access_size)
         SIZE_BYTE: last = 2'd0;
         SIZE_HALF: last = 2'd1;
         SIZE_WORD: last = 2'd3;
         default: begin
            last     = 2'd3;
            bad_size = 1'b1;
         end
      endcase
   end

   // reads check and start at the aligned address, writes at the given one
   assign base = (req_payload.action == ACT_WRITE) ? req_payload.address
                                                   : (req_payload.address & ~{30'b0, last});
   assign limit = (33'(valid_bytes_ff) > 33'(MEM_BYTES)) ? 33'(MEM_BYTES)
                                                         : 33'(valid_bytes_ff);
   assign end_addr = {1'b0, base} + {31'b0, last} + 33'd1;

   assign busy = q_status.full;
   assign push = start && !busy;

   always_comb begin
      push_cmd.write      = (req_payload.action == ACT_WRITE);
      push_cmd.fault      = bad_size || (end_addr > limit);
      push_cmd.msb_first  = msb_first_ff;
      push_cmd.last       = last;
      push_cmd.rot        = (req_payload.action == ACT_WRITE) ? 2'd0
                                                              : (req_payload.address[1:0] & last);
      push_cmd.address    = base;
      push_cmd.write_data = req_payload.write_data;
   end
endmodule
`default_nettype wire

>>> rtl/bmb_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "byte_memory_bus_rotated_loads_assert.svh"
module bmb_back #(
   parameter int unsigned MEM_BYTES = bmb_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bmb_pkg::q_status_type q_status,
   input  wire bmb_pkg::cmd_type      q_cmd,
   output logic                       pop,
   output logic                       rsp_strobe,
   output bmb_pkg::rsp_type           rsp_payload
);
   import bmb_pkg::*;

   localparam int unsigned AW = $clog2(MEM_BYTES);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_type;

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [1:0]    pend_lane_ff, pend_lane_in;
   logic [31:0]   acc_ff, acc_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [1:0]    lane;
   logic [31:0]   merged;
   logic [31:0]   ram_addr_full;
   logic          ram_we;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;
   logic          fault_rsp;
   logic          read_done;

   bmb_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(MEM_BYTES)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr_full[AW-1:0]),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign ram_addr_full = cmd_ff.address + 32'(cnt_ff);
   assign lane          = byte_lane(cmd_ff.msb_first, cmd_ff.last, cnt_ff);
   assign ram_wdata     = get_byte(cmd_ff.write_data, lane);
   assign merged        = set_byte(acc_ff, pend_lane_ff, ram_rdata);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_lane_in  = pend_lane_ff;
      acc_in        = pend_ff ? merged : acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               cnt_in = 2'd0;
               acc_in = '0;
               if (q_cmd.fault) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.read_data = '0;
                  rsp_in.fault     = 1'b1;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cmd_ff.write) begin
               ram_we = 1'b1;
            end else begin
               pend_in      = 1'b1;
               pend_lane_in = lane;
            end
            if (cnt_ff == cmd_ff.last) begin
               if (cmd_ff.write) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.read_data = '0;
                  rsp_in.fault     = 1'b0;
                  state_in         = S_IDLE;
               end else begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.read_data = rotate_bytes(merged, cmd_ff.rot);
            rsp_in.fault     = 1'b0;
            state_in         = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      pend_lane_ff <= pend_lane_in;
      acc_ff       <= acc_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   assign fault_rsp = rsp_strobe_ff && rsp_ff.fault;
   assign read_done = (state_ff == S_RUN) && !cmd_ff.write && (cnt_ff == cmd_ff.last);

   `BMB_ASSERT_IMPLIES(a_fault_reads_zero, clock, reset, fault_rsp, rsp_ff.read_data == '0)
   `BMB_ASSERT_NEXT(a_read_drains, clock, reset, read_done, state_ff == S_DRAIN && pend_ff)
   `BMB_ASSERT_IMPLIES(a_pop_only_idle, clock, reset, pop, state_ff == S_IDLE)
endmodule
`default_nettype wire

>>> rtl/byte_memory_bus_rotated_loads.sv
`timescale 1ns / 1ps
`default_nettype none
// byte-addressed memory with 8/16/32-bit reads and writes and selectable byte order.
// an access is taken on start when busy is low; every access gives exactly one result,
// shown on rsp_payload for one cycle with rsp_strobe high, and the receiver cannot stall
// it. reads align to the access size and come back rotated right by the dropped low
// address bytes; writes store at the address as given. an access that reaches past the
// smaller of the valid-byte register and MEM_BYTES, or has access size 3, returns fault
// with zero read data and writes nothing. the front classifies and range-checks each
// access and drops it into a two-entry queue; the back moves one byte per cycle through
// a single byte-wide ram port. from queue head to result: a fault is answered straight
// from idle, a write once its last byte is stored, and a read after one more drain state
// for the registered ram output. busy rises only while the queue is full. memory
// contents are undefined until written; there is no clearing pass.
// configuration writes take effect at the next edge and belong in idle periods.
module byte_memory_bus_rotated_loads #(
   parameter int unsigned MEM_BYTES = bmb_pkg::MEM_BYTES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // access request
   input  wire logic                                start,
   input  wire bmb_pkg::req_type                    req_payload,
   output logic                                     busy,
   // access result
   output logic                                     rsp_strobe,
   output bmb_pkg::rsp_type                         rsp_payload,
   // configuration writes
   input  wire logic                                csr_write_en,
   input  wire logic [bmb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bmb_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bmb_pkg::*;

   // queue between front and back
   q_status_type q_status;
   logic         push;
   cmd_type      push_cmd;
   logic         pop;
   cmd_type      head_cmd;

   // front: config registers, size decode, range check, transfer into the queue
   bmb_front #(
      .MEM_BYTES(MEM_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   bmb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head_cmd(head_cmd),
      .status  (q_status)
   );

   // back: byte-serial ram sequencing, read assembly and rotation
   bmb_back #(
      .MEM_BYTES(MEM_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_cmd      (head_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );
endmodule
`default_nettype wire

>>> verif/rotated_load_checker.sv
`timescale 1ns / 1ps
module rotated_load_checker #(
   parameter int unsigned MEM_BYTES = bmb_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  bmb_pkg::req_type                   req_payload,
   input  logic                               rsp_strobe,
   input  bmb_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_write_en,
   input  logic [bmb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bmb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                 pending_results,
   output int                                 error_count
);
   import bmb_pkg::*;

   logic [7:0]            shadow_bytes [0:MEM_BYTES-1];
   logic                  cfg_msb_first;
   logic [CSR_DATA_W-1:0] cfg_valid_bytes;
   rsp_type               expected_results [$];

   // result of one access, updating the shadow memory on a good write
   function automatic rsp_type predict_access(input req_type a);
      rsp_type         r;
      longint unsigned limit;
      longint unsigned first;
      int unsigned     len;
      int unsigned     offset;
      int unsigned     pos;
      logic [31:0]     word;
      r = '0;
      limit = (cfg_valid_bytes > MEM_BYTES) ? MEM_BYTES : cfg_valid_bytes;
      case (a.access_size)
         SIZE_BYTE: len = 1;
         SIZE_HALF: len = 2;
         SIZE_WORD: len = 4;
         default:   len = 0;
      endcase
      offset = a.address & (len - 1);
      // reads check the aligned address, writes the given one
      first = (a.action == ACT_WRITE) ? a.address : a.address - offset;
      if (len == 0 || first + len > limit) begin
         r.fault = 1'b1;
      end else if (a.action == ACT_WRITE) begin
         for (int k = 0; k < len; k++) begin
            pos = cfg_msb_first ? len - 1 - k : k;
            shadow_bytes[first + pos] = a.write_data[8*k +: 8];
         end
      end else begin
         word = '0;
         for (int k = 0; k < len; k++) begin
            pos = cfg_msb_first ? k : len - 1 - k;
            word = {word[23:0], shadow_bytes[first + pos]};
         end
         r.read_data = 32'({word, word} >> (8 * offset));
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         expected_results.delete();
         cfg_msb_first = 1'b0;
         cfg_valid_bytes = VALID_BYTES_RESET;
         error_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing pending: read_data %h fault %b",
                        $time, rsp_payload.read_data, rsp_payload.fault);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_payload.read_data);
                  error_count++;
               end
               if (rsp_payload.fault !== want.fault) begin
                  $display("%0t: fault expected %b actual %b",
                           $time, want.fault, rsp_payload.fault);
                  error_count++;
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_MSB_FIRST:   cfg_msb_first = csr_wdata[0];
               CSR_VALID_BYTES: cfg_valid_bytes = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_results.push_back(predict_access(req_payload));
         end
      end
      pending_results = expected_results.size();
   end

endmodule

>>> verif/byte_memory_bus_rotated_loads_test.sv
`timescale 1ns / 1ps
module byte_memory_bus_rotated_loads_test;
   import bmb_pkg::*;

   // access size with no meaning, always faults
   localparam logic [1:0] SIZE_UNUSED = 2'd3;
   // generous bound on the whole run, a hard stop well past any correct run
   localparam int RUN_LIMIT = 200000;
   // cycles allowed after the last result before touching the registers
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 20;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   req_type                req_payload;
   logic                   busy;
   logic                   rsp_strobe;
   rsp_type                rsp_payload;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     pending_results;
   int                     error_count;
   int                     cycle_count = 0;

   // bytes already stored, so reads never touch undefined memory
   bit                     stored_mask [0:MEM_BYTES_DEFAULT-1];
   // current valid byte limit, as programmed by the stimulus
   longint unsigned        valid_limit = MEM_BYTES_DEFAULT;

   byte_memory_bus_rotated_loads uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_payload  (req_payload),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   rotated_load_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_payload     (req_payload),
      .rsp_strobe      (rsp_strobe),
      .rsp_payload     (rsp_payload),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .error_count     (error_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type make_access(input logic act, input logic [1:0] size,
                                           input logic [31:0] addr, input logic [31:0] data);
      req_type a;
      a.action      = act;
      a.access_size = size;
      a.address     = addr;
      a.write_data  = data;
      return a;
   endfunction

   // byte count of an access, zero for the unused size
   function automatic int unsigned access_bytes(input logic [1:0] size);
      case (size)
         SIZE_BYTE: return 1;
         SIZE_HALF: return 2;
         SIZE_WORD: return 4;
         default:   return 0;
      endcase
   endfunction

   // a read is fine if it faults or every byte it covers was stored before
   function automatic bit read_allowed(input req_type a);
      int unsigned     len;
      longint unsigned base;
      len = access_bytes(a.access_size);
      if (len == 0) return 1'b1;
      base = a.address & ~(len - 1);
      if (base + len > valid_limit) return 1'b1;
      for (int k = 0; k < len; k++) begin
         if (!stored_mask[base + k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // track which bytes a non-faulting write fills
   function automatic void note_write(input req_type a);
      int unsigned len;
      len = access_bytes(a.access_size);
      if (a.action != ACT_WRITE || len == 0) return;
      if (longint'(a.address) + len > valid_limit) return;
      for (int k = 0; k < len; k++) stored_mask[a.address + k] = 1'b1;
   endfunction

   // random access, mostly aimed at the low window and the top of valid memory
   function automatic req_type random_access();
      req_type         a;
      int unsigned     pick;
      longint unsigned near_top;
      a.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
      a.access_size = ($urandom_range(0, 9) == 0) ? SIZE_UNUSED
                                                  : 2'($urandom_range(SIZE_BYTE, SIZE_WORD));
      pick = $urandom_range(0, 99);
      near_top = (valid_limit > 6) ? valid_limit - 6 : 0;
      if (pick < 50) begin
         a.address = $urandom_range(0, 47);
      end else if (pick < 70) begin
         a.address = 32'(near_top) + $urandom_range(0, 9);
      end else if (pick < 80) begin
         a.address = $urandom_range(0, MEM_BYTES_DEFAULT - 1);
      end else if (pick < 90) begin
         a.address = $urandom();
      end else begin
         // just below 2^32, where a wrapping range check would go wrong
         a.address = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) a.write_data = '1;
      else if (pick < 15) a.write_data = '0;
      else a.write_data = $urandom();
      return a;
   endfunction

   // one request transfer; a read of unstored bytes is turned into a write
   task automatic send_access(input req_type item);
      req_type a;
      a = item;
      if (a.action == ACT_READ && !read_allowed(a)) a.action = ACT_WRITE;
      note_write(a);
      start       <= 1'b1;
      req_payload <= a;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // registers change only once every result is back
   task automatic reconfigure(input logic big, input logic [CSR_DATA_W-1:0] size);
      start <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MSB_FIRST;
      csr_wdata    <= CSR_DATA_W'(big);
      @(posedge clock);
      csr_index    <= CSR_VALID_BYTES;
      csr_wdata    <= size;
      @(posedge clock);
      csr_write_en <= 1'b0;
      valid_limit = (size > MEM_BYTES_DEFAULT) ? MEM_BYTES_DEFAULT : size;
   endtask

   // random traffic in bursts with gaps of random length, some back to back
   task automatic run_random(input int count);
      int burst_left;
      int gap;
      int pick;
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         send_access(random_access());
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            pick = $urandom_range(0, 99);
            if (pick < 30) gap = 0;
            else if (pick < 85) gap = $urandom_range(1, 4);
            else gap = $urandom_range(8, 20);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   initial begin
      reset        <= 1'b1;
      start        <= 1'b0;
      req_payload  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_MSB_FIRST;
      csr_wdata    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: little endian, full memory
      send_access(make_access(ACT_WRITE, SIZE_WORD, 32'd0, 32'h1122_3344));
      send_access(make_access(ACT_WRITE, SIZE_WORD, 32'd4, 32'hA5C3_0F81));
      send_access(make_access(ACT_READ, SIZE_BYTE, 32'd1, 32'h0));
      send_access(make_access(ACT_READ, SIZE_HALF, 32'd0, 32'h0));
      // odd halfword read comes back rotated by one byte
      send_access(make_access(ACT_READ, SIZE_HALF, 32'd1, 32'h0));
      // word reads at each of the four byte offsets
      send_access(make_access(ACT_READ, SIZE_WORD, 32'd0, 32'h0));
      send_access(make_access(ACT_READ, SIZE_WORD, 32'd1, 32'h0));
      send_access(make_access(ACT_READ, SIZE_WORD, 32'd2, 32'h0));
      send_access(make_access(ACT_READ, SIZE_WORD, 32'd3, 32'h0));
      send_access(make_access(ACT_WRITE, SIZE_WORD, 32'd8, 32'hFFFF_FFFF));
      // unaligned write lands at the address as given, low bits only
      send_access(make_access(ACT_WRITE, SIZE_HALF, 32'd9, 32'h1234_BEEF));
      send_access(make_access(ACT_READ, SIZE_WORD, 32'd11, 32'h0));
      send_access(make_access(ACT_READ, SIZE_HALF, 32'd9, 32'h0));
      send_access(make_access(ACT_WRITE, SIZE_BYTE, 32'd12, 32'h0));
      send_access(make_access(ACT_READ, SIZE_BYTE, 32'd12, 32'h0));
      // last word of memory, an unaligned read of it, then a write that runs past the end
      send_access(make_access(ACT_WRITE, SIZE_WORD, 32'd65532, 32'h8000_0001));
      send_access(make_access(ACT_READ, SIZE_WORD, 32'd65535, 32'h0));
      send_access(make_access(ACT_WRITE, SIZE_WORD, 32'd65533, 32'hDEAD_BEEF));
      send_access(make_access(ACT_WRITE, SIZE_BYTE, 32'd65535, 32'h0000_007E));
      send_access(make_access(ACT_READ, SIZE_HALF, 32'd65535, 32'h0));
      // top of the address space must not wrap into range
      send_access(make_access(ACT_READ, SIZE_WORD, 32'hFFFF_FFFF, 32'h0));
      send_access(make_access(ACT_WRITE, SIZE_BYTE, 32'hFFFF_FFFF, 32'h0000_00AA));
      // unused access size faults on both directions
      send_access(make_access(ACT_READ, SIZE_UNUSED, 32'd0, 32'h0));
      send_access(make_access(ACT_WRITE, SIZE_UNUSED, 32'd4, 32'h5555_AAAA));

      // random phases over byte order and memory sizes, extremes included
      reconfigure(1'b1, CSR_DATA_W'(65536));
      run_random(300);
      reconfigure(1'b0, CSR_DATA_W'(4));
      run_random(150);
      // zero size, every access faults
      reconfigure(1'b1, CSR_DATA_W'(0));
      run_random(60);
      // register maximum, clamps to the physical size
      reconfigure(1'b0, CSR_DATA_W'(131071));
      run_random(300);
      reconfigure(1'b1, CSR_DATA_W'(3));
      run_random(150);
      reconfigure(1'b0, CSR_DATA_W'($urandom_range(4, 65536)));
      run_random(300);
      reconfigure(1'b1, CSR_DATA_W'($urandom_range(4, 65536)));
      run_random(300);
      reconfigure(1'b0, CSR_DATA_W'(1));
      run_random(60);
      reconfigure(1'b0, CSR_DATA_W'(65536));
      run_random(300);

      // drain, then give the verdict
      start <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
